FILE: src/epcal_pkg.sv
// ----------------------------------------------------------------------------
// epcal_pkg: shared types and constants for the epoch-to-calendar converter
// Microcode word layout, step and opcode codes, time constants, month table.
// ----------------------------------------------------------------------------
package epcal_pkg;

  // time-of-day constants; one day of seconds fits in 17 bits
  localparam int unsigned REM_W = 17;
  localparam logic [REM_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [REM_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [REM_W-1:0] SECS_PER_MIN  = 17'd60;

  // seconds per year and per month, for stepping whole units off the count
  localparam int unsigned YSECS_W = 25;
  localparam logic [YSECS_W-1:0] SECS_PER_COMMON_YEAR = 25'd31536000;
  localparam logic [YSECS_W-1:0] SECS_PER_LEAP_YEAR   = 25'd31622400;
  localparam int unsigned MSECS_W = 22;

  // calendar constants
  localparam int unsigned BASE_YEAR     = 1970;
  localparam logic [6:0]  BASE_MOD100   = 7'd70;   // 1970 mod 100
  localparam logic [8:0]  BASE_MOD400   = 9'd370;  // 1970 mod 400
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;    // epoch day was a Thursday
  localparam logic [8:0]  DAYS_LEAP     = 9'd366;
  localparam logic [8:0]  DAYS_COMMON   = 9'd365;
  localparam logic [3:0]  LAST_MONTH    = 4'd12;

  // result packing: 12+4+5+5+6+6+3+9 = 50 bits, padded to 56
  localparam int unsigned OUT_TDATA_W = 56;

  // sequencer step addresses
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_YEAR  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MONTH = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DAY   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_HOUR  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MIN   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DONE  = 3'd5;

  // datapath operations
  localparam logic [2:0] OP_YEAR  = 3'd0;  // take one year off the count
  localparam logic [2:0] OP_MONTH = 3'd1;  // take one month off the count
  localparam logic [2:0] OP_DAY   = 3'd2;  // take one day off the count
  localparam logic [2:0] OP_HOUR  = 3'd3;  // take one hour off the count
  localparam logic [2:0] OP_MIN   = 3'd4;  // take one minute off the count
  localparam logic [2:0] OP_DONE  = 3'd5;  // hand the result to the output stage

  // jump conditions
  localparam logic [1:0] COND_ALWAYS = 2'd0;
  localparam logic [1:0] COND_STOP   = 2'd2;  // loop compare says value is below
  localparam logic [1:0] COND_SLOT   = 2'd3;  // output register free

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
  } ucw_t;

  // control store: jump to target when cond holds, else repeat the step
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    case (step)
      STEP_YEAR:  w = '{op: OP_YEAR,  cond: COND_STOP,   target: STEP_MONTH};
      STEP_MONTH: w = '{op: OP_MONTH, cond: COND_STOP,   target: STEP_DAY};
      STEP_DAY:   w = '{op: OP_DAY,   cond: COND_STOP,   target: STEP_HOUR};
      STEP_HOUR:  w = '{op: OP_HOUR,  cond: COND_STOP,   target: STEP_MIN};
      STEP_MIN:   w = '{op: OP_MIN,   cond: COND_STOP,   target: STEP_DONE};
      STEP_DONE:  w = '{op: OP_DONE,  cond: COND_SLOT,   target: STEP_YEAR};
      default:    w = '{op: OP_DONE,  cond: COND_SLOT,   target: STEP_YEAR};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // seconds in a month of the given length
  function automatic logic [MSECS_W-1:0] month_secs(input logic [4:0] ndays);
    logic [MSECS_W-1:0] s;
    case (ndays)
      5'd28:   s = 22'd2419200;
      5'd29:   s = 22'd2505600;
      5'd30:   s = 22'd2592000;
      default: s = 22'd2678400;
    endcase
    return s;
  endfunction

endpackage

FILE: src/epoch_seconds_to_calendar.sv
// Conversion time grows with the years, months, days, hours and minutes stepped off,
//   and the result waits while the output register stays full.
// Throughput: one item at a time; the next input is taken the cycle after the result
//   enters the output register, set by the single shared subtract datapath.
// Reset: synchronous, active low; clears sequencer busy flag, step and output valid.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970-01-01 to Gregorian fields
// Microcoded sequencer driving one subtract/compare datapath.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar #(
  parameter int unsigned SECONDS_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: [SECONDS_WIDTH-1:0] epoch_seconds, rest zero padding
  input  logic [((SECONDS_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: [11:0] year_number, [15:12] month_number, [20:16] day_of_month,
  //   [25:21] hour_of_day, [31:26] minute_of_hour, [37:32] second_of_minute,
  //   [40:38] day_of_week, [49:41] day_of_year, [55:50] zero
  output logic [epcal_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import epcal_pkg::*;

  localparam int unsigned SW = SECONDS_WIDTH;
  // A year is more than 2^24 seconds, so years past the epoch stay below
  // 2^(SW-24); the year register holds 1970 plus that.
  localparam int unsigned YW = (SW - 23 > 12) ? SW - 23 : 12;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic                    busy_r;
  logic [STEP_W-1:0]       pc_r;
  logic                    out_tvalid_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_r;

  // acc_r holds the second count, worn down by the year, month, day, hour and
  // minute loops; what is left at the end is the second of the minute.
  logic [SW-1:0]           acc_r;
  logic [2:0]              wday_r;    // weekday, counted on from the epoch day
  logic [YW-1:0]           year_r;
  logic [6:0]              y100_r;    // year mod 100 (low 2 bits give mod 4)
  logic [8:0]              y400_r;    // year mod 400
  logic [3:0]              month_r;
  logic [4:0]              mday_r;    // zero-based day of month
  logic [8:0]              yday_r;    // zero-based day of year
  logic [4:0]              hour_r;
  logic [5:0]              min_r;

  // ---------------------------------------------------------------------------
  // Decode and datapath
  // ---------------------------------------------------------------------------
  ucw_t               ucw;
  logic               in_xfer;
  logic               slot_free;
  logic               leap;
  logic [YSECS_W-1:0] ysecs;
  logic [4:0]         mlen;
  logic [MSECS_W-1:0] msecs;
  logic [1:0]         wstep;
  logic [3:0]         wplus;
  logic [2:0]         wday_add;
  logic               stop;
  logic               take;

  assign ucw       = ucode(pc_r);
  assign in_tready = !busy_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;

  assign leap  = (y400_r == 9'd0) || ((y100_r != 7'd0) && (y100_r[1:0] == 2'd0));
  assign ysecs = leap ? SECS_PER_LEAP_YEAR : SECS_PER_COMMON_YEAR;
  assign mlen  = month_days(month_r, leap);
  assign msecs = month_secs(mlen);

  // weekday advance: 365 and 366 days are 1 and 2 mod 7; month lengths
  // 28..31 are 0..3 mod 7, which is just the low two bits
  always_comb begin
    case (ucw.op)
      OP_YEAR:  wstep = leap ? 2'd2 : 2'd1;
      OP_MONTH: wstep = mlen[1:0];
      default:  wstep = 2'd1;
    endcase
  end

  assign wplus    = {1'b0, wday_r} + {2'b0, wstep};
  assign wday_add = (wplus >= 4'd7) ? 3'(wplus - 4'd7) : wplus[2:0];

  always_comb begin
    case (ucw.op)
      OP_YEAR:  stop = acc_r < SW'(ysecs);
      OP_MONTH: stop = (acc_r < SW'(msecs)) || (month_r >= LAST_MONTH);
      OP_DAY:   stop = acc_r < SW'(SECS_PER_DAY);
      OP_HOUR:  stop = acc_r < SW'(SECS_PER_HOUR);
      OP_MIN:   stop = acc_r < SW'(SECS_PER_MIN);
      default:  stop = 1'b0;
    endcase
  end

  always_comb begin
    case (ucw.cond)
      COND_ALWAYS: take = 1'b1;
      COND_STOP:   take = stop;
      COND_SLOT:   take = slot_free;
      default:     take = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pc_r         <= STEP_YEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_r <= 1'b1;
        pc_r   <= STEP_YEAR;
      end else if (busy_r && take) begin
        pc_r <= ucw.target;
        if (ucw.op == OP_DONE) begin
          busy_r <= 1'b0;
        end
      end
      if (busy_r && ucw.op == OP_DONE && slot_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers (no reset needed)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_r   <= in_tdata[SW-1:0];
      wday_r  <= EPOCH_WEEKDAY;
      year_r  <= YW'(BASE_YEAR);
      y100_r  <= BASE_MOD100;
      y400_r  <= BASE_MOD400;
      month_r <= 4'd1;
      mday_r  <= '0;
      yday_r  <= '0;
      hour_r  <= '0;
      min_r   <= '0;
    end else if (busy_r) begin
      case (ucw.op)
        OP_YEAR: begin
          if (!stop) begin
            acc_r  <= acc_r - SW'(ysecs);
            year_r <= year_r + 1'b1;
            y100_r <= (y100_r == 7'd99) ? 7'd0 : y100_r + 1'b1;
            y400_r <= (y400_r == 9'd399) ? 9'd0 : y400_r + 1'b1;
            wday_r <= wday_add;
          end
        end
        OP_MONTH: begin
          if (!stop) begin
            acc_r   <= acc_r - SW'(msecs);
            month_r <= month_r + 1'b1;
            yday_r  <= yday_r + {4'd0, mlen};
            wday_r  <= wday_add;
          end
        end
        OP_DAY: begin
          if (!stop) begin
            acc_r  <= acc_r - SW'(SECS_PER_DAY);
            mday_r <= mday_r + 1'b1;
            yday_r <= yday_r + 1'b1;
            wday_r <= wday_add;
          end
        end
        OP_HOUR: begin
          if (!stop) begin
            acc_r  <= acc_r - SW'(SECS_PER_HOUR);
            hour_r <= hour_r + 1'b1;
          end
        end
        OP_MIN: begin
          if (!stop) begin
            acc_r <= acc_r - SW'(SECS_PER_MIN);
            min_r <= min_r + 1'b1;
          end
        end
        OP_DONE: begin
          if (slot_free) begin
            out_tdata_r <= {6'd0,
                            9'(yday_r + 1'b1),
                            wday_r,
                            acc_r[5:0],
                            min_r,
                            hour_r,
                            5'(mday_r + 1'b1),
                            month_r,
                            year_r[11:0]};
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> busy_r && pc_r == STEP_YEAR)
    else $error("conversion did not start at the year step");

  a_month: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && pc_r == STEP_MONTH |-> month_r >= 4'd1 && month_r <= LAST_MONTH)
    else $error("month counter out of range");

  a_wday: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> wday_r < 3'd7)
    else $error("weekday out of range");

  a_min: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && pc_r == STEP_MIN |-> acc_r < SW'(SECS_PER_HOUR))
    else $error("hour loop left more than an hour");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && pc_r == STEP_DONE && slot_free |=> out_tvalid && !busy_r)
    else $error("finished result not posted");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for epoch_seconds_to_calendar
// Streams epoch second counts into the converter and compares every calendar
// result, field by field, with a typed-in answer or a local calendar predictor.
// ----------------------------------------------------------------------------
module tb;
  import epcal_pkg::*;

  localparam int unsigned SECONDS_WIDTH = 32;
  localparam int unsigned IN_TDATA_W    = ((SECONDS_WIDTH + 7) / 8) * 8;
  localparam int unsigned RANDOM_DATES  = 1030;
  // worst case is the longest conversion plus handshake stalls per transfer
  localparam int unsigned CYCLE_LIMIT   = 1500000;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned LAST_DAY      = 49709;  // last full day below 2**32 seconds

  // Field order is reversed so the packed layout lines up with out_tdata[49:0]:
  // year_number sits in the low bits, day_of_year in the high bits.
  typedef struct packed {
    logic [8:0]  day_of_year;
    logic [2:0]  day_of_week;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_number;
  } calendar_t;

  // One directed probe: the count to send, and a hand-written answer where the
  // answer is obvious (epoch, end of first day, Y2K, top of the 32-bit range).
  typedef struct packed {
    logic [31:0] secs;
    logic        known;
    calendar_t   want;
  } probe_t;

  localparam int unsigned NUM_PROBES = 22;
  localparam probe_t PROBES [NUM_PROBES] = '{
    // 1970-01-01 00:00:00, Thursday
    '{32'd0, 1'b1, '{day_of_year: 9'd1, day_of_week: 3'd4, second_of_minute: 6'd0,
                     minute_of_hour: 6'd0, hour_of_day: 5'd0, day_of_month: 5'd1,
                     month_number: 4'd1, year_number: 12'd1970}},
    // 1970-01-01 23:59:59
    '{32'd86399, 1'b1, '{day_of_year: 9'd1, day_of_week: 3'd4, second_of_minute: 6'd59,
                         minute_of_hour: 6'd59, hour_of_day: 5'd23, day_of_month: 5'd1,
                         month_number: 4'd1, year_number: 12'd1970}},
    // 2000-01-01 00:00:00, Saturday
    '{32'd946684800, 1'b1, '{day_of_year: 9'd1, day_of_week: 3'd6, second_of_minute: 6'd0,
                             minute_of_hour: 6'd0, hour_of_day: 5'd0, day_of_month: 5'd1,
                             month_number: 4'd1, year_number: 12'd2000}},
    // 2106-02-07 06:28:15, Sunday: all ones
    '{32'hFFFF_FFFF, 1'b1, '{day_of_year: 9'd38, day_of_week: 3'd0, second_of_minute: 6'd15,
                             minute_of_hour: 6'd28, hour_of_day: 5'd6, day_of_month: 5'd7,
                             month_number: 4'd2, year_number: 12'd2106}},
    '{32'd86400,      1'b0, '0},  // second day
    '{32'd31535999,   1'b0, '0},  // 1970-12-31 23:59:59
    '{32'd31536000,   1'b0, '0},  // 1971-01-01
    '{32'd68169599,   1'b0, '0},  // 1972-02-28 23:59:59
    '{32'd68169600,   1'b0, '0},  // 1972-02-29, first leap day
    '{32'd68256000,   1'b0, '0},  // 1972-03-01
    '{32'd94694399,   1'b0, '0},  // 1972-12-31 23:59:59, day 366
    '{32'd946684799,  1'b0, '0},  // 1999-12-31 23:59:59
    '{32'd951782400,  1'b0, '0},  // 2000-02-29, leap by the 400 rule
    '{32'd978307199,  1'b0, '0},  // 2000-12-31 23:59:59, day 366
    '{32'd1234567890, 1'b0, '0},
    '{32'd2147483647, 1'b0, '0},  // top of signed 32-bit range
    '{32'd2147483648, 1'b0, '0},
    '{32'd4102444799, 1'b0, '0},  // 2099-12-31 23:59:59
    '{32'd4107542399, 1'b0, '0},  // 2100-02-28 23:59:59, no leap day in 2100
    '{32'd4107542400, 1'b0, '0},  // 2100-03-01
    '{32'h5555_5555,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0}
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]        in_tdata = '0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [OUT_TDATA_W-1:0]       out_tdata;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;

  calendar_t   pending_dates[$];  // expected results, oldest first
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 67;

  epoch_seconds_to_calendar #(.SECONDS_WIDTH(SECONDS_WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #5 clk = ~clk;

  function automatic bit is_leap(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  // Calendar breakdown of a second count: whole days, then years, then months.
  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   c;
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned mo;
    int unsigned ylen;
    int unsigned mlen;
    int unsigned yday;
    days = secs / 86400;
    rem  = secs % 86400;
    c.day_of_week = 3'((days + EPOCH_WEEKDAY) % 7);
    yr = BASE_YEAR;
    forever begin
      ylen = is_leap(yr) ? DAYS_LEAP : DAYS_COMMON;
      if (days < ylen) break;
      days -= ylen;
      yr++;
    end
    yday = days;
    mo = 1;
    forever begin
      case (mo)
        2:           mlen = is_leap(yr) ? 29 : 28;
        4, 6, 9, 11: mlen = 30;
        default:     mlen = 31;
      endcase
      if (days < mlen || mo >= LAST_MONTH) break;
      days -= mlen;
      mo++;
    end
    c.year_number      = 12'(yr);
    c.month_number     = 4'(mo);
    c.day_of_month     = 5'(days + 1);
    c.hour_of_day      = 5'(rem / 3600);
    c.minute_of_hour   = 6'((rem % 3600) / 60);
    c.second_of_minute = 6'(rem % 60);
    c.day_of_year      = 9'(yday + 1);
    return c;
  endfunction

  // Drive one count, starting and ending at a falling edge. The expectation is
  // queued on the rising edge where the transfer happens.
  task automatic send_seconds(input logic [31:0] secs, input calendar_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(secs);
    do @(posedge clk); while (!in_tready);
    pending_dates.push_back(want);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Receiver stalls; held low through reset.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: every output transfer against the oldest expectation.
  calendar_t got_date;
  calendar_t want_date;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_date = calendar_t'(out_tdata[$bits(calendar_t)-1:0]);
      if (pending_dates.size() == 0) begin
        $error("unexpected result transfer: out_tdata %h", out_tdata);
        error_count++;
      end else begin
        want_date = pending_dates.pop_front();
        check_field("year_number",      want_date.year_number,      got_date.year_number);
        check_field("month_number",     want_date.month_number,     got_date.month_number);
        check_field("day_of_month",     want_date.day_of_month,     got_date.day_of_month);
        check_field("hour_of_day",      want_date.hour_of_day,      got_date.hour_of_day);
        check_field("minute_of_hour",   want_date.minute_of_hour,   got_date.minute_of_hour);
        check_field("second_of_minute", want_date.second_of_minute, got_date.second_of_minute);
        check_field("day_of_week",      want_date.day_of_week,      got_date.day_of_week);
        check_field("day_of_year",      want_date.day_of_year,      got_date.day_of_year);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  logic [31:0] secs;
  int unsigned pick;
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed probes: typed-in answers where known, predictor otherwise.
    foreach (PROBES[i]) begin
      send_seconds(PROBES[i].secs,
                   PROBES[i].known ? PROBES[i].want : calendar_of(PROBES[i].secs));
    end

    // Random counts in three idle regimes: receiver-heavy stalls, sender-heavy
    // gaps, then back to back.
    for (int unsigned k = 0; k < RANDOM_DATES; k++) begin
      case (k * 3 / RANDOM_DATES)
        0:       begin send_idle_pct = 37; recv_idle_pct = 67; end
        1:       begin send_idle_pct = 67; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      pick = $urandom_range(99);
      if (pick < 45) begin
        secs = $urandom;
      end else if (pick < 85) begin
        // day-aligned counts hit month, year and leap-day boundaries often
        secs = $urandom_range(LAST_DAY) * 86400;
        case ($urandom_range(2))
          0:       secs = secs;
          1:       secs = secs + 86399;
          default: secs = secs + $urandom_range(86399);
        endcase
      end else if (pick < 93) begin
        secs = 32'hFFFF_FFFF - $urandom_range(200000);
      end else begin
        secs = $urandom_range(200000);
      end
      send_seconds(secs, calendar_of(secs));
    end
    in_tvalid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
